// ===== rtl/fppp_pkg.sv =====
// ----------------------------------------------------------------------------
// fppp_pkg
// shared types and constants of the fixed point perspective projection unit
// ----------------------------------------------------------------------------
package fppp_pkg;

   localparam int unsigned QUOT_BITS = 31;   // quotient magnitude bits
   localparam int unsigned NUM_W     = 63;   // numerator magnitude width

   localparam logic [1:0] STATUS_SKIPPED   = 2'd0;
   localparam logic [1:0] STATUS_PROJECTED = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   localparam logic [2:0] REG_SCALE_X     = 3'd0;
   localparam logic [2:0] REG_SCALE_Y     = 3'd1;
   localparam logic [2:0] REG_SCALE_Z     = 3'd2;
   localparam logic [2:0] REG_HALF_WIDTH  = 3'd3;
   localparam logic [2:0] REG_HALF_HEIGHT = 3'd4;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               already_projected;
      logic               behind_viewer;
   } req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic [1:0]         status;
   } rsp_type;

   // config values seen by the datapath
   typedef struct packed {
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic [30:0]        half_width;
      logic [30:0]        half_height;
   } cfg_type;

   // divider state carried down the pipe
   typedef struct packed {
      logic [NUM_W-1:0]     rem_x;
      logic [NUM_W-1:0]     rem_y;
      logic [QUOT_BITS-1:0] quo_x;
      logic [QUOT_BITS-1:0] quo_y;
      logic [31:0]          dvs;
      logic                 neg_x;
      logic                 neg_y;
      logic                 skip;
      logic                 ovf;
   } div_type;

endpackage

// ===== rtl/fppp_front.sv =====
// ----------------------------------------------------------------------------
// fppp_front
// scale multiply, numerator multiply, magnitude and range precheck stages
// ----------------------------------------------------------------------------
module fppp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  fppp_pkg::req_type in_data,
   input  fppp_pkg::cfg_type cfg,
   output logic             out_valid,
   output fppp_pkg::div_type out_data
);

   logic [3:0] vld_ff, vld_in;

   // stage 1: scaled coordinates
   logic signed [31:0] vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic               skip1_ff, skip1_in;
   logic signed [63:0] px, py, pz;

   // stage 2: numerators
   logic signed [62:0] nx_ff, ny_ff, nx_in, ny_in;
   logic signed [31:0] vz2_ff, vz2_in;
   logic               skip2_ff, skip2_in;
   logic signed [63:0] mx, my;

   // stage 3: magnitudes
   logic [62:0] ax_ff, ay_ff, ax_in, ay_in;
   logic [31:0] dv_ff, dv_in;
   logic        sx_ff, sy_ff, sx_in, sy_in, skip3_ff, skip3_in;

   // stage 4: precheck
   fppp_pkg::div_type pre_ff, pre_in;
   logic [62:0]       dv_top;

   assign vld_in = {vld_ff[2:0], in_valid};

   always_comb begin
      px = in_data.point_x * cfg.scale_x;
      py = in_data.point_y * cfg.scale_y;
      pz = in_data.point_z * cfg.scale_z;
      vx_in = px[47:16];
      vy_in = py[47:16];
      vz_in = pz[47:16];
      skip1_in = in_data.already_projected | in_data.behind_viewer;

      mx = vx_ff * $signed({1'b0, cfg.half_width});
      my = vy_ff * $signed({1'b0, cfg.half_height});
      nx_in = mx[62:0];
      ny_in = my[62:0];
      vz2_in = vz_ff;
      skip2_in = skip1_ff;

      // quotient sign from numerator and depth signs
      sx_in = nx_ff[62] ^ vz2_ff[31];
      sy_in = ny_ff[62] ^ vz2_ff[31];
      ax_in = nx_ff[62] ? 63'(-nx_ff) : 63'(nx_ff);
      ay_in = ny_ff[62] ? 63'(-ny_ff) : 63'(ny_ff);
      dv_in = vz2_ff[31] ? 32'(-vz2_ff) : 32'(vz2_ff);
      skip3_in = skip2_ff;

      // quotient at or above 2^31 when magnitude reaches divisor shifted by 31
      dv_top = {dv_ff, 31'd0};
      pre_in.rem_x = ax_ff;
      pre_in.rem_y = ay_ff;
      pre_in.quo_x = '0;
      pre_in.quo_y = '0;
      pre_in.dvs   = dv_ff;
      pre_in.neg_x = sx_ff;
      pre_in.neg_y = sy_ff;
      pre_in.skip  = skip3_ff;
      pre_in.ovf   = (dv_ff == 32'd0) || (ax_ff >= dv_top) || (ay_ff >= dv_top);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vz_ff <= vz_in;
         skip1_ff <= skip1_in;
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         vz2_ff <= vz2_in;
         skip2_ff <= skip2_in;
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         dv_ff <= dv_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         skip3_ff <= skip3_in;
         pre_ff <= pre_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_data  = pre_ff;

endmodule

// ===== rtl/fppp_div_step.sv =====
// ----------------------------------------------------------------------------
// fppp_div_step
// one restoring division step for both lanes, one quotient bit
// ----------------------------------------------------------------------------
module fppp_div_step #(
   parameter int unsigned BIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  fppp_pkg::div_type in_data,
   output logic             out_valid,
   output fppp_pkg::div_type out_data
);

   logic              vld_ff;
   fppp_pkg::div_type stg_ff, stg_in;
   logic [fppp_pkg::NUM_W-1:0] sub_val;

   always_comb begin
      sub_val = {31'd0, in_data.dvs} << BIT;
      stg_in  = in_data;
      if (in_data.rem_x >= sub_val) begin
         stg_in.rem_x      = in_data.rem_x - sub_val;
         stg_in.quo_x[BIT] = 1'b1;
      end
      if (in_data.rem_y >= sub_val) begin
         stg_in.rem_y      = in_data.rem_y - sub_val;
         stg_in.quo_y[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stg_ff <= stg_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = stg_ff;

endmodule

// ===== rtl/fixed_point_perspective_project_unit.sv =====
// pipeline: 4 front stages, 31 divide steps, 1 output stage between req beat and rsp beat
// throughput: one beat per cycle unless rsp stalls, set by the one-bit-per-stage divider chain
// a stalled rsp beat freezes the whole pipe; req_ready is low only then
// reset: synchronous active high; clears valid bits and loads the register defaults
// ----------------------------------------------------------------------------
// fixed_point_perspective_project_unit
// 16.16 perspective projection of view-space points with apb register port
// ----------------------------------------------------------------------------
module fixed_point_perspective_project_unit (
   input  logic              clock,
   input  logic              reset,
   // point beats in
   input  logic              req_valid,
   output logic              req_ready,
   input  fppp_pkg::req_type req_data,
   // screen beats out
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fppp_pkg::rsp_type rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // ---------------------------------------------------------------- registers
   fppp_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        reg_idx;
   logic              wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            fppp_pkg::REG_SCALE_X:     cfg_in.scale_x     = pwdata;
            fppp_pkg::REG_SCALE_Y:     cfg_in.scale_y     = pwdata;
            fppp_pkg::REG_SCALE_Z:     cfg_in.scale_z     = pwdata;
            fppp_pkg::REG_HALF_WIDTH:  cfg_in.half_width  = pwdata[30:0];
            fppp_pkg::REG_HALF_HEIGHT: cfg_in.half_height = pwdata[30:0];
            default:                   cfg_in = cfg_ff;  // unmapped address
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_x     <= 32'sd65536;
         cfg_ff.scale_y     <= 32'sd65536;
         cfg_ff.scale_z     <= 32'sd65536;
         cfg_ff.half_width  <= 31'd20971520;
         cfg_ff.half_height <= 31'd13107200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         fppp_pkg::REG_SCALE_X:     prdata = cfg_ff.scale_x;
         fppp_pkg::REG_SCALE_Y:     prdata = cfg_ff.scale_y;
         fppp_pkg::REG_SCALE_Z:     prdata = cfg_ff.scale_z;
         fppp_pkg::REG_HALF_WIDTH:  prdata = {1'b0, cfg_ff.half_width};
         fppp_pkg::REG_HALF_HEIGHT: prdata = {1'b0, cfg_ff.half_height};
         default:                   prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- pipe control
   // every stage moves together; only a held output beat stops the pipe
   logic advance;
   logic rsp_vld_ff;

   assign advance   = ~rsp_vld_ff | rsp_ready;
   assign req_ready = advance;

   // ---------------------------------------------------------------- front
   logic              chain_vld [0:fppp_pkg::QUOT_BITS];
   fppp_pkg::div_type chain_dat [0:fppp_pkg::QUOT_BITS];

   fppp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (chain_vld[0]),
      .out_data  (chain_dat[0])
   );

   // ---------------------------------------------------------------- divider chain
   // msb first: stage k resolves quotient bit 30-k
   for (genvar k = 0; k < fppp_pkg::QUOT_BITS; k++) begin : g_div
      fppp_div_step #(
         .BIT (fppp_pkg::QUOT_BITS - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_vld[k]),
         .in_data   (chain_dat[k]),
         .out_valid (chain_vld[k+1]),
         .out_data  (chain_dat[k+1])
      );
   end

   // ---------------------------------------------------------------- output stage
   fppp_pkg::div_type fin;
   fppp_pkg::rsp_type rsp_ff, rsp_in;
   logic signed [31:0] tx, ty;

   assign fin = chain_dat[fppp_pkg::QUOT_BITS];

   always_comb begin
      // restore the sign of the truncated quotient
      tx = fin.neg_x ? -$signed({1'b0, fin.quo_x}) : $signed({1'b0, fin.quo_x});
      ty = fin.neg_y ? -$signed({1'b0, fin.quo_y}) : $signed({1'b0, fin.quo_y});
      if (fin.skip) begin
         rsp_in.screen_x = '0;
         rsp_in.screen_y = '0;
         rsp_in.status   = fppp_pkg::STATUS_SKIPPED;
      end else if (fin.ovf) begin
         rsp_in.screen_x = '0;
         rsp_in.screen_y = '0;
         rsp_in.status   = fppp_pkg::STATUS_OVERFLOW;
      end else begin
         // centre plus x offset, centre minus y offset, wrapping
         rsp_in.screen_x = $signed({1'b0, cfg_ff.half_width}) + tx;
         rsp_in.screen_y = $signed({1'b0, cfg_ff.half_height}) - ty;
         rsp_in.status   = fppp_pkg::STATUS_PROJECTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= chain_vld[fppp_pkg::QUOT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/fppp_checker.sv =====
// ----------------------------------------------------------------------------
// fppp_checker
// port level checks of the projection unit, bound to the top level
// ----------------------------------------------------------------------------
module fppp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fppp_pkg::rsp_type rsp_data
);

   // a held rsp beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // only projected beats carry screen coordinates
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != fppp_pkg::STATUS_PROJECTED |->
         rsp_data.screen_x == 32'sd0 && rsp_data.screen_y == 32'sd0)
      else $error("skipped or overflow beat with nonzero coordinates");

   // an empty output never blocks the input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

bind fixed_point_perspective_project_unit fppp_checker u_fppp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
